// ----- sv/kmss_pkg.sv -----
// Shared sizes and codes for the key matrix scanner and serial sender.
// No dependencies; imported by the top level.
package kmss_pkg;

  localparam int FIFO_DEPTH = 64;
  localparam int ROW_COUNT  = 8;
  localparam int ROW_BITS   = 32;

  localparam int ROW_IDX_W  = 3;
  localparam int KEYS_W     = 32;
  localparam int BIT_IDX_W  = 5;
  localparam int CODE_W     = 8;
  localparam int FRAME_W    = 10;

  localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int ROW_AW     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  localparam logic [CODE_W-1:0] PRESS_FLAG = 8'h80;

  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_TICK = 1'b1;

endpackage

// ----- sv/key_matrix_scan_serial_sender_unit.sv -----
// Key matrix scanner with code FIFO and serial frame sender.
// Depends on kmss_pkg for sizes and codes.
// A tick beat gives its line bit, registered, in the cycle after acceptance. A scan
// beat reads the row memory, compares and writes back in ST_CMP, then handles one
// changed key per cycle in ST_SCAN (sent straight away if the sender is idle, else
// written to the FIFO memory, dropped if it is full), then sees that none is left.
// A frame-ending tick with codes waiting reads the FIFO; ST_LOAD loads the next frame.
// Reset (async, active low) empties the FIFO, idles the sender and marks every
// stored row as all keys released; no clearing pass is needed.
module key_matrix_scan_serial_sender_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic [kmss_pkg::ROW_IDX_W-1:0]   row_index_i,
  input  logic [kmss_pkg::KEYS_W-1:0]      row_keys_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             serial_bit_o,
  output logic                             frame_done_o
);
  import kmss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // accept beats
    ST_CMP  = 4'b0010,  // compare row with stored copy
    ST_SCAN = 4'b0100,  // queue one changed key per cycle
    ST_LOAD = 4'b1000   // load next frame from FIFO read data
  } state_e;

  state_e state_q, state_d;

  // Stored rows: one entry per matrix row, sync read.
  logic [ROW_BITS-1:0] row_mem [ROW_COUNT];
  logic [ROW_BITS-1:0] row_rd_q;
  logic [ROW_COUNT-1:0] row_vld_q, row_vld_d;

  // Code FIFO, sync read.
  logic [CODE_W-1:0] fifo_mem [FIFO_DEPTH];
  logic [CODE_W-1:0] fifo_rd_q;

  logic [FIFO_AW-1:0] head_q, head_d;
  logic [FIFO_AW-1:0] tail_q, tail_d;
  logic [FIFO_CW-1:0] count_q, count_d;

  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               sending_q, sending_d;

  logic [ROW_IDX_W-1:0] row_q;
  logic [ROW_BITS-1:0]  keys_q;
  logic [ROW_BITS-1:0]  diff_q, diff_d;

  logic out_valid_q, out_valid_d;
  logic serial_q, serial_d;
  logic done_q, done_d;

  logic in_accept;
  logic row_in_range;
  logic row_rd_en;
  logic fifo_rd_en;
  logic fifo_wr_en;
  logic row_wr_en;
  logic [CODE_W-1:0] code;
  logic [BIT_IDX_W-1:0] bit_idx;
  logic pressed;
  logic fifo_full;
  logic [ROW_BITS-1:0] prev_row;
  logic [FRAME_W-1:0] frame_shift;

  // Hold input while working or while the output slot cannot drain.
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign row_in_range = ({1'b0, row_index_i} < (ROW_IDX_W + 1)'(ROW_COUNT));
  assign fifo_full    = (count_q == FIFO_CW'(FIFO_DEPTH));

  // Unwritten rows read as all keys released.
  assign prev_row = row_vld_q[row_q[ROW_AW-1:0]] ? row_rd_q : '1;

  // Pick the lowest changed key.
  always_comb begin
    bit_idx = '0;
    pressed = 1'b0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (diff_q[i]) begin
        bit_idx = BIT_IDX_W'(i);
        pressed = ~keys_q[i];
      end
    end
  end

  assign code = {row_q, bit_idx} | (pressed ? PRESS_FLAG : '0);
  assign frame_shift = {1'b0, frame_q[FRAME_W-1:1]};

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    frame_d     = frame_q;
    sending_d   = sending_q;
    diff_d      = diff_q;
    row_vld_d   = row_vld_q;
    serial_d    = serial_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && out_stall_i;
    row_rd_en   = 1'b0;
    row_wr_en   = 1'b0;
    fifo_rd_en  = 1'b0;
    fifo_wr_en  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (mode_i == MODE_SCAN) begin
            if (row_in_range) begin
              row_rd_en = 1'b1;
              state_d   = ST_CMP;
            end
          end else if (sending_q) begin
            // Emit one line bit; the stop bit empties the frame.
            out_valid_d = 1'b1;
            serial_d    = frame_q[0];
            frame_d     = frame_shift;
            done_d      = (frame_shift == '0);
            if (frame_shift == '0) begin
              sending_d = 1'b0;
              if (count_q != '0) begin
                fifo_rd_en = 1'b1;
                state_d    = ST_LOAD;
              end
            end
          end
        end
      end
      ST_CMP: begin
        diff_d    = keys_q ^ prev_row;
        row_wr_en = 1'b1;
        row_vld_d[row_q[ROW_AW-1:0]] = 1'b1;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        if (diff_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          diff_d = diff_q & (diff_q - ROW_BITS'(1));
          if (!sending_q) begin
            // FIFO is empty while idle: send the code straight away.
            frame_d   = {1'b1, code, 1'b0};
            sending_d = 1'b1;
          end else if (!fifo_full) begin
            fifo_wr_en = 1'b1;
            count_d    = count_q + FIFO_CW'(1);
            tail_d     = (tail_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : tail_q + FIFO_AW'(1);
          end
        end
      end
      ST_LOAD: begin
        frame_d   = {1'b1, fifo_rd_q, 1'b0};
        sending_d = 1'b1;
        count_d   = count_q - FIFO_CW'(1);
        head_d    = (head_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : head_q + FIFO_AW'(1);
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      frame_q     <= '0;
      sending_q   <= 1'b0;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      frame_q     <= frame_d;
      sending_q   <= sending_d;
      row_vld_q   <= row_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    serial_q <= serial_d;
    done_q   <= done_d;
    diff_q   <= diff_d;
    if (in_accept) begin
      row_q  <= row_index_i;
      keys_q <= row_keys_i[ROW_BITS-1:0];
    end
  end

  // Row memory.
  always_ff @(posedge clk_i) begin
    if (row_rd_en) begin
      row_rd_q <= row_mem[row_index_i[ROW_AW-1:0]];
    end
    if (row_wr_en) begin
      row_mem[row_q[ROW_AW-1:0]] <= keys_q;
    end
  end

  // FIFO memory; reads and writes never overlap in one scan or load.
  always_ff @(posedge clk_i) begin
    if (fifo_rd_en) begin
      fifo_rd_q <= fifo_mem[head_q];
    end
    if (fifo_wr_en) begin
      fifo_mem[tail_q] <= code;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign serial_bit_o = serial_q;
  assign frame_done_o = done_q;

  // Fill level never passes the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("fifo count overflow");

  // An idle sender between beats means an empty FIFO.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !sending_q) |-> (count_q == '0))
    else $error("codes left waiting while sender idle");

  // A frame load always restarts the sender.
  a_load_sends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> sending_q)
    else $error("frame load did not start sending");

  // A new line bit only follows an accepted tick.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && out_stall_i)) |->
      $past(in_accept && mode_i == MODE_TICK && sending_q))
    else $error("line bit without tick");

endmodule
